### hdl/qrsb_pkg.sv
// ----------------------------------------------------------------------------
// qrsb_pkg: shared types and constants for the quartic root scanner
// Holds the default parameters, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package qrsb_pkg;

    localparam int DEF_MAX_ROOTS     = 8;
    localparam int DEF_FRACTION_BITS = 24;

    localparam int DATA_W  = 32;
    localparam int TOL_W   = 25;
    localparam int SUB_W   = 10;
    localparam int CFG_W   = 25;
    localparam int NUM_W   = 3;

    localparam logic CFG_TOLERANCE    = 1'b0;
    localparam logic CFG_SUBDIVISIONS = 1'b1;

    localparam logic [TOL_W-1:0] TOL_RESET = 25'd16777;
    localparam logic [SUB_W-1:0] SUB_RESET = 10'd100;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_SIGN_LO,
        ST_SCAN,
        ST_REF_INIT,
        ST_REF_TEST,
        ST_REF_MID,
        ST_EMIT,
        ST_NONE
    } state_t;

    typedef struct packed {
        logic start;
    } req_t;

endpackage

### hdl/quartic_root_scan_bisection_core.sv
// ----------------------------------------------------------------------------
// quartic_root_scan_bisection_core: root scanner for x^4 - 18x^2 + 6
// Scans an interval in N steps, bisects each marked step, emits the roots.
//
//   channel   signals                                          dir
//   in        in_valid, in_ready, lower_end, upper_end         in
//   out       out_valid, out_ready, root_value .. last         out
//   cfg       cfg_we, cfg_index, cfg_data                      in
//
// Each interval is accepted, divided to get the step width, then scanned with
// N+1 sign evaluations. Each marked step takes a sign evaluation of its left
// end, one per bisection step, and an emit of its result. All sign evaluations
// go through the shared sign unit (one 32x32 multiplier).
// in_ready is high only while idle; a stalled output holds the sequencer.
// Reset is asynchronous; registers return to tolerance 16777, N = 100.
// ----------------------------------------------------------------------------
module quartic_root_scan_bisection_core #(
    parameter int MAX_ROOTS     = qrsb_pkg::DEF_MAX_ROOTS,
    parameter int FRACTION_BITS = qrsb_pkg::DEF_FRACTION_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [qrsb_pkg::DATA_W-1:0]   lower_end,
    input  logic signed [qrsb_pkg::DATA_W-1:0]   upper_end,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [qrsb_pkg::DATA_W-1:0]   root_value,
    output logic signed [qrsb_pkg::DATA_W-1:0]   bracket_left,
    output logic signed [qrsb_pkg::DATA_W-1:0]   bracket_right,
    output logic [qrsb_pkg::NUM_W-1:0]           root_number,
    output logic                                 found,
    output logic                                 overflow,
    output logic                                 last,
    input  logic                                 cfg_we,
    input  logic                                 cfg_index,
    input  logic [qrsb_pkg::CFG_W-1:0]           cfg_data
);
    localparam int DW = qrsb_pkg::DATA_W;
    localparam int XW = DW + 2;
    localparam int RW = (MAX_ROOTS > 1) ? $clog2(MAX_ROOTS) : 1;
    localparam int KW = $clog2(MAX_ROOTS + 1);
    localparam int SW = qrsb_pkg::SUB_W;

    qrsb_pkg::state_t state_reg, state_next;

    logic [qrsb_pkg::TOL_W-1:0] tol_reg;
    logic [SW-1:0]              sub_reg;

    logic signed [XW-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic signed [XW-1:0] h_reg, h_next, left_reg, left_next;
    logic signed [XW-1:0] a_reg, a_next, b_reg, b_next, c_reg, c_next;
    logic [SW-1:0]        n_reg, n_next, i_reg, i_next;
    logic [1:0]           sl_reg, sl_next, sa_reg, sa_next;
    logic [KW-1:0]        kept_reg, kept_next, k_reg, k_next;
    logic                 ovf_reg, ovf_next;
    logic                 wait_reg, wait_next;

    logic signed [DW-1:0] lefts_mem [MAX_ROOTS];
    logic signed [DW-1:0] rights_mem [MAX_ROOTS];
    logic                 mem_we;
    logic [RW-1:0]        mem_wa, mem_ra;
    logic signed [DW-1:0] rd_left_reg, rd_right_reg;

    logic                 ov_reg, ov_next;
    logic signed [DW-1:0] o_root_reg, o_root_next, o_l_reg, o_l_next, o_r_reg, o_r_next;
    logic [qrsb_pkg::NUM_W-1:0] o_num_reg, o_num_next;
    logic o_fnd_reg, o_fnd_next, o_ovf_reg, o_ovf_next, o_last_reg, o_last_next;

    qrsb_pkg::req_t       sreq;
    logic signed [DW-1:0] sx;
    logic                 sbusy, sdone;
    logic [1:0]           scode;

    logic                 dstart, ddone;
    logic [DW:0]          dquo;

    logic signed [XW-1:0] width, lim, r_cand;
    logic                 opp_scan, opp_ref;

    qrsb_sign_unit #(.FRACTION_BITS(FRACTION_BITS)) u_sign (
        .clk(clk), .rst_n(rst_n), .req(sreq), .x(sx),
        .busy(sbusy), .done(sdone), .sign_code(scode)
    );

    qrsb_divider u_div (
        .clk(clk), .rst_n(rst_n), .start(dstart),
        .dividend((DW+1)'(hi_reg - lo_reg)),
        .divisor(n_reg), .done(ddone), .quotient(dquo)
    );

    assign width    = b_reg - a_reg;
    assign lim      = XW'({tol_reg, 1'b0});
    assign r_cand   = (i_reg == n_reg - SW'(1)) ? hi_reg : left_reg + h_reg;
    assign opp_scan = (sl_reg == 2'b00) || (scode == 2'b00) || (sl_reg != scode);
    assign opp_ref  = (sa_reg == 2'b00) || (scode == 2'b00) || (sa_reg != scode);

    always_comb
    begin
        state_next = state_reg;
        lo_next = lo_reg; hi_next = hi_reg; h_next = h_reg;
        left_next = left_reg; a_next = a_reg; b_next = b_reg; c_next = c_reg;
        n_next = n_reg; i_next = i_reg; sl_next = sl_reg; sa_next = sa_reg;
        kept_next = kept_reg; k_next = k_reg; ovf_next = ovf_reg;
        wait_next = wait_reg;
        ov_next = ov_reg;
        o_root_next = o_root_reg; o_l_next = o_l_reg; o_r_next = o_r_reg;
        o_num_next = o_num_reg; o_fnd_next = o_fnd_reg; o_ovf_next = o_ovf_reg;
        o_last_next = o_last_reg;
        sreq = '0; sx = '0; dstart = 1'b0;
        mem_we = 1'b0; mem_wa = RW'(kept_reg); mem_ra = RW'(k_reg);
        in_ready = 1'b0;
        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end
        case (state_reg)
            qrsb_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    lo_next   = XW'(lower_end);
                    hi_next   = XW'(upper_end);
                    n_next    = (sub_reg == '0) ? SW'(1) : sub_reg;
                    kept_next = '0;
                    ovf_next  = 1'b0;
                    k_next    = '0;
                    state_next = (upper_end < lower_end) ? qrsb_pkg::ST_NONE
                                                         : qrsb_pkg::ST_DIV;
                    wait_next = 1'b0;
                end
            end
            qrsb_pkg::ST_DIV:
            begin
                if (!wait_reg)
                begin
                    dstart = 1'b1;
                    wait_next = 1'b1;
                end
                else if (ddone)
                begin
                    h_next = XW'($signed({1'b0, dquo}));
                    left_next = lo_reg;
                    i_next = '0;
                    wait_next = 1'b0;
                    state_next = qrsb_pkg::ST_SIGN_LO;
                end
            end
            qrsb_pkg::ST_SIGN_LO:
            begin
                sx = DW'(lo_reg);
                if (!wait_reg)
                begin
                    sreq.start = 1'b1;
                    wait_next = 1'b1;
                end
                else if (sdone)
                begin
                    sl_next = scode;
                    wait_next = 1'b0;
                    state_next = qrsb_pkg::ST_SCAN;
                end
            end
            qrsb_pkg::ST_SCAN:
            begin
                sx = DW'(r_cand);
                if (!wait_reg)
                begin
                    sreq.start = 1'b1;
                    wait_next = 1'b1;
                end
                else if (sdone)
                begin
                    wait_next = 1'b0;
                    if (opp_scan)
                    begin
                        if (kept_reg < KW'(MAX_ROOTS))
                        begin
                            mem_we = 1'b1;
                            kept_next = kept_reg + KW'(1);
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                    left_next = r_cand;
                    sl_next = scode;
                    i_next = i_reg + SW'(1);
                    if (i_reg == n_reg - SW'(1))
                    begin
                        state_next = (kept_next == '0) ? qrsb_pkg::ST_NONE
                                                       : qrsb_pkg::ST_REF_INIT;
                    end
                end
            end
            qrsb_pkg::ST_REF_INIT:
            begin
                // read data lands in the cycle after entry
                sx = rd_left_reg;
                if (!wait_reg)
                begin
                    wait_next = 1'b1;
                end
                else if (!sbusy && !sdone && c_reg != XW'(1))
                begin
                    a_next = XW'(rd_left_reg);
                    b_next = XW'(rd_right_reg);
                    sreq.start = 1'b1;
                    c_next = XW'(1);
                end
                else if (sdone)
                begin
                    sa_next = scode;
                    c_next = '0;
                    wait_next = 1'b0;
                    state_next = qrsb_pkg::ST_REF_TEST;
                end
            end
            qrsb_pkg::ST_REF_TEST:
            begin
                if (width > lim && width >= XW'(2))
                begin
                    c_next = a_reg + (width >>> 1);
                    state_next = qrsb_pkg::ST_REF_MID;
                end
                else if (!ov_reg || out_ready)
                begin
                    ov_next = 1'b1;
                    o_root_next = DW'(a_reg + (width >>> 1));
                    o_l_next = rd_left_reg;
                    o_r_next = rd_right_reg;
                    o_num_next = qrsb_pkg::NUM_W'(k_reg);
                    o_fnd_next = 1'b1;
                    o_ovf_next = ovf_reg;
                    o_last_next = (k_reg == kept_reg - KW'(1));
                    k_next = k_reg + KW'(1);
                    state_next = (k_reg == kept_reg - KW'(1)) ? qrsb_pkg::ST_EMIT
                                                               : qrsb_pkg::ST_REF_INIT;
                end
            end
            qrsb_pkg::ST_REF_MID:
            begin
                sx = DW'(c_reg);
                if (!wait_reg)
                begin
                    sreq.start = 1'b1;
                    wait_next = 1'b1;
                end
                else if (sdone)
                begin
                    wait_next = 1'b0;
                    if (opp_ref)
                    begin
                        b_next = c_reg;
                    end
                    else
                    begin
                        a_next = c_reg;
                        sa_next = scode;
                    end
                    c_next = '0;
                    state_next = qrsb_pkg::ST_REF_TEST;
                end
            end
            qrsb_pkg::ST_NONE:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next = 1'b1;
                    o_root_next = '0; o_l_next = '0; o_r_next = '0; o_num_next = '0;
                    o_fnd_next = 1'b0; o_ovf_next = 1'b0; o_last_next = 1'b1;
                    state_next = qrsb_pkg::ST_EMIT;
                end
            end
            qrsb_pkg::ST_EMIT:
            begin
                if (!ov_next)
                begin
                    state_next = qrsb_pkg::ST_IDLE;
                end
            end
            default: state_next = qrsb_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= qrsb_pkg::ST_IDLE;
            tol_reg   <= qrsb_pkg::TOL_RESET;
            sub_reg   <= qrsb_pkg::SUB_RESET;
            ov_reg    <= 1'b0;
            wait_reg  <= 1'b0;
            c_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            wait_reg  <= wait_next;
            c_reg     <= c_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    qrsb_pkg::CFG_TOLERANCE:    tol_reg <= cfg_data;
                    qrsb_pkg::CFG_SUBDIVISIONS: sub_reg <= cfg_data[SW-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg <= lo_next; hi_reg <= hi_next; h_reg <= h_next;
        left_reg <= left_next; a_reg <= a_next; b_reg <= b_next;
        n_reg <= n_next; i_reg <= i_next; sl_reg <= sl_next; sa_reg <= sa_next;
        kept_reg <= kept_next; k_reg <= k_next; ovf_reg <= ovf_next;
        o_root_reg <= o_root_next; o_l_reg <= o_l_next; o_r_reg <= o_r_next;
        o_num_reg <= o_num_next; o_fnd_reg <= o_fnd_next; o_ovf_reg <= o_ovf_next;
        o_last_reg <= o_last_next;
        if (mem_we)
        begin
            lefts_mem[mem_wa]  <= DW'(left_reg);
            rights_mem[mem_wa] <= DW'(r_cand);
        end
        rd_left_reg  <= lefts_mem[mem_ra];
        rd_right_reg <= rights_mem[mem_ra];
    end

    assign out_valid     = ov_reg;
    assign root_value    = o_root_reg;
    assign bracket_left  = o_l_reg;
    assign bracket_right = o_r_reg;
    assign root_number   = o_num_reg;
    assign found         = o_fnd_reg;
    assign overflow      = o_ovf_reg;
    assign last          = o_last_reg;
endmodule

### hdl/qrsb_sign_unit.sv
// ----------------------------------------------------------------------------
// qrsb_sign_unit: multi-cycle sign of f(x) = x^4 - 18x^2 + 6
// Squares |x| then squares again on one shared 32x32 multiplier; exact compare.
// ----------------------------------------------------------------------------
module qrsb_sign_unit #(
    parameter int FRACTION_BITS = qrsb_pkg::DEF_FRACTION_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  qrsb_pkg::req_t               req,
    input  logic signed [qrsb_pkg::DATA_W-1:0] x,
    output logic                         busy,
    output logic                         done,
    output logic [1:0]                   sign_code
);
    localparam int W  = 4 * FRACTION_BITS + 72;
    localparam int DW = qrsb_pkg::DATA_W;

    logic [1:0]      phase_reg, phase_next;
    logic [DW-1:0]   mag_reg, mag_next;
    logic [2*DW-1:0] sq_reg, sq_next;
    logic [1:0]      lane_reg, lane_next;
    logic [W-1:0]    acc_reg, acc_next;
    logic            done_reg, done_next;
    logic [1:0]      sign_reg, sign_next;

    logic [DW-1:0]   ma, mb;
    logic [2*DW-1:0] prod;
    logic [W-1:0]    p_val, q_val, six;

    assign prod = ma * mb;
    assign six  = W'(6) << (4 * FRACTION_BITS);
    assign q_val = (W'(sq_reg) * W'(18)) << (2 * FRACTION_BITS);
    assign p_val = acc_reg + six;

    always_comb
    begin
        ma = mag_reg;
        mb = mag_reg;
        case (phase_reg)
            2'd2:
            begin
                ma = sq_reg[DW-1:0];
                mb = (lane_reg != 2'd0) ? sq_reg[2*DW-1:DW] : sq_reg[DW-1:0];
                if (lane_reg == 2'd3)
                begin
                    ma = sq_reg[2*DW-1:DW];
                end
            end
            default:
            begin
                ma = mag_reg;
                mb = mag_reg;
            end
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        mag_next   = mag_reg;
        sq_next    = sq_reg;
        lane_next  = lane_reg;
        acc_next   = acc_reg;
        done_next  = 1'b0;
        sign_next  = sign_reg;
        case (phase_reg)
            2'd0:
            begin
                if (req.start)
                begin
                    mag_next   = x[DW-1] ? DW'(-x) : DW'(x);
                    phase_next = 2'd1;
                end
            end
            2'd1:
            begin
                sq_next    = prod;
                acc_next   = '0;
                lane_next  = 2'd0;
                phase_next = 2'd2;
            end
            2'd2:
            begin
                case (lane_reg)
                    2'd0: acc_next = acc_reg + W'(prod);
                    2'd3: acc_next = acc_reg + (W'(prod) << (2 * DW));
                    default: acc_next = acc_reg + (W'(prod) << DW);
                endcase
                lane_next = lane_reg + 2'd1;
                if (lane_reg == 2'd3)
                begin
                    phase_next = 2'd3;
                end
            end
            2'd3:
            begin
                sign_next  = (p_val > q_val) ? 2'b01 : ((p_val == q_val) ? 2'b00 : 2'b11);
                done_next  = 1'b1;
                phase_next = 2'd0;
            end
            default: phase_next = 2'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 2'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        sq_reg   <= sq_next;
        lane_reg <= lane_next;
        acc_reg  <= acc_next;
        sign_reg <= sign_next;
    end

    assign busy      = (phase_reg != 2'd0);
    assign done      = done_reg;
    assign sign_code = sign_reg;
endmodule

### hdl/qrsb_divider.sv
// ----------------------------------------------------------------------------
// qrsb_divider: restoring divider, one quotient bit per cycle
// Computes floor(span / n) for the step width of the scan grid.
// ----------------------------------------------------------------------------
module qrsb_divider (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [qrsb_pkg::DATA_W:0]    dividend,
    input  logic [qrsb_pkg::SUB_W-1:0]   divisor,
    output logic                         done,
    output logic [qrsb_pkg::DATA_W:0]    quotient
);
    localparam int NW = qrsb_pkg::DATA_W + 1;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0]                  quo_reg, quo_next;
    logic [qrsb_pkg::SUB_W:0]       rem_reg, rem_next;
    logic [CW-1:0]                  cnt_reg, cnt_next;
    logic                           run_reg, run_next;
    logic                           done_reg, done_next;
    logic [qrsb_pkg::SUB_W:0]       trial;

    assign trial = {rem_reg[qrsb_pkg::SUB_W-1:0], quo_reg[NW-1]};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next = dividend;
            rem_next = '0;
            cnt_next = CW'(NW);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (trial >= {1'b0, divisor})
            begin
                rem_next = trial - {1'b0, divisor};
                quo_next = {quo_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

### tb/sv/quartic_root_scan_bisection_checker.sv
// ----------------------------------------------------------------------------
// quartic_root_scan_bisection_checker: result predictor and scoreboard
// Watches the interval, result and register ports of the root scanner,
// predicts the roots of every accepted interval and compares each result
// transaction field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module quartic_root_scan_bisection_checker #(
    parameter int MAX_ROOTS     = qrsb_pkg::DEF_MAX_ROOTS,
    parameter int FRACTION_BITS = qrsb_pkg::DEF_FRACTION_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic                                 in_ready,
    input  logic signed [qrsb_pkg::DATA_W-1:0]   lower_end,
    input  logic signed [qrsb_pkg::DATA_W-1:0]   upper_end,
    input  logic                                 out_valid,
    input  logic                                 out_ready,
    input  logic signed [qrsb_pkg::DATA_W-1:0]   root_value,
    input  logic signed [qrsb_pkg::DATA_W-1:0]   bracket_left,
    input  logic signed [qrsb_pkg::DATA_W-1:0]   bracket_right,
    input  logic [qrsb_pkg::NUM_W-1:0]           root_number,
    input  logic                                 found,
    input  logic                                 overflow,
    input  logic                                 last,
    input  logic                                 cfg_we,
    input  logic                                 cfg_index,
    input  logic [qrsb_pkg::CFG_W-1:0]           cfg_data,
    output int                                   errors,
    output int                                   pending
);
    typedef struct packed {
        logic [qrsb_pkg::DATA_W-1:0] root;
        logic [qrsb_pkg::DATA_W-1:0] left_end;
        logic [qrsb_pkg::DATA_W-1:0] right_end;
        logic [qrsb_pkg::NUM_W-1:0]  num;
        logic                        fnd;
        logic                        ovf;
        logic                        lst;
    } root_rec_t;

    root_rec_t                  root_queue[$];
    logic [qrsb_pkg::TOL_W-1:0] tol_q;
    logic [qrsb_pkg::SUB_W-1:0] sub_q;
    int                         err_cnt;

    assign errors = err_cnt;

    function automatic int quartic_sign(longint x);
        logic [191:0] mag;
        logic [191:0] lhs;
        logic [191:0] rhs;
        logic [63:0]  m;
        m   = (x < 0) ? -x : x;
        m   = m & 64'hFFFF_FFFF;
        mag = 192'(m);
        lhs = mag * mag * mag * mag + (192'd6 << (4 * FRACTION_BITS));
        rhs = (mag * mag * 192'd18) << (2 * FRACTION_BITS);
        if (lhs > rhs)
            return 1;
        if (lhs < rhs)
            return -1;
        return 0;
    endfunction

    function automatic bit sign_flips(int s1, int s2);
        return s1 == 0 || s2 == 0 || s1 != s2;
    endfunction

    function automatic longint bisect(longint a_in, longint b_in);
        longint a;
        longint b;
        longint c;
        longint lim;
        int     sa;
        int     sc;
        a   = a_in;
        b   = b_in;
        lim = 2 * longint'(tol_q);
        sa  = quartic_sign(a);
        while (b - a > lim && b - a >= 2)
        begin
            c  = a + (b - a) / 2;
            sc = quartic_sign(c);
            if (sign_flips(sa, sc))
                b = c;
            else
            begin
                a  = c;
                sa = sc;
            end
        end
        return a + (b - a) / 2;
    endfunction

    task automatic predict_roots(longint lo, longint hi);
        longint    lefts[MAX_ROOTS];
        longint    rights[MAX_ROOTS];
        longint    n;
        longint    h;
        longint    lft;
        longint    rgt;
        int        sl;
        int        sr;
        int        kept;
        bit        ovf;
        root_rec_t rec;
        kept = 0;
        ovf  = 0;
        if (hi >= lo)
        begin
            n   = (sub_q == 0) ? 1 : longint'(sub_q);
            h   = (hi - lo) / n;
            lft = lo;
            sl  = quartic_sign(lft);
            for (longint i = 0; i < n; i++)
            begin
                rgt = (i == n - 1) ? hi : lo + (i + 1) * h;
                sr  = quartic_sign(rgt);
                if (sign_flips(sl, sr))
                begin
                    if (kept < MAX_ROOTS)
                    begin
                        lefts[kept]  = lft;
                        rights[kept] = rgt;
                        kept++;
                    end
                    else
                        ovf = 1;
                end
                lft = rgt;
                sl  = sr;
            end
        end
        if (kept == 0)
        begin
            rec        = '0;
            rec.lst    = 1'b1;
            root_queue = {root_queue, rec};
        end
        for (int k = 0; k < kept; k++)
        begin
            rec.root      = qrsb_pkg::DATA_W'(bisect(lefts[k], rights[k]));
            rec.left_end  = qrsb_pkg::DATA_W'(lefts[k]);
            rec.right_end = qrsb_pkg::DATA_W'(rights[k]);
            rec.num       = qrsb_pkg::NUM_W'(k);
            rec.fnd       = 1'b1;
            rec.ovf       = ovf;
            rec.lst       = (k == kept - 1);
            root_queue    = {root_queue, rec};
        end
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        err_cnt++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        root_rec_t rec;
        if (!rst_n)
        begin
            tol_q   <= qrsb_pkg::TOL_RESET;
            sub_q   <= qrsb_pkg::SUB_RESET;
            err_cnt = 0;
            root_queue.delete();
            pending = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (root_queue.size() == 0)
                    report_mismatch("unexpected result", 64'(root_value), 64'd0);
                else
                begin
                    rec = root_queue.pop_front();
                    if (root_value !== rec.root)
                        report_mismatch("root_value", 64'(root_value), 64'(rec.root));
                    if (bracket_left !== rec.left_end)
                        report_mismatch("bracket_left", 64'(bracket_left), 64'(rec.left_end));
                    if (bracket_right !== rec.right_end)
                        report_mismatch("bracket_right", 64'(bracket_right),
                                        64'(rec.right_end));
                    if (root_number !== rec.num)
                        report_mismatch("root_number", 64'(root_number), 64'(rec.num));
                    if (found !== rec.fnd)
                        report_mismatch("found", 64'(found), 64'(rec.fnd));
                    if (overflow !== rec.ovf)
                        report_mismatch("overflow", 64'(overflow), 64'(rec.ovf));
                    if (last !== rec.lst)
                        report_mismatch("last", 64'(last), 64'(rec.lst));
                end
            end
            if (in_valid && in_ready)
                predict_roots(longint'(lower_end), longint'(upper_end));
            if (cfg_we)
            begin
                if (cfg_index == qrsb_pkg::CFG_TOLERANCE)
                    tol_q <= cfg_data[qrsb_pkg::TOL_W-1:0];
                else
                    sub_q <= cfg_data[qrsb_pkg::SUB_W-1:0];
            end
            pending = root_queue.size();
        end
    end

endmodule

### tb/sv/quartic_root_scan_bisection_core_tb.sv
// ----------------------------------------------------------------------------
// quartic_root_scan_bisection_core_tb: top level bench for the root scanner
// Drives search intervals and register writes in phases, stalls both
// channels at random, and reports the verdict from the checker's count.
// ----------------------------------------------------------------------------
module quartic_root_scan_bisection_core_tb;

    localparam int IDLE_LIMIT = 400000;
    localparam longint ONE    = 64'sd1 << qrsb_pkg::DEF_FRACTION_BITS;

    logic                               clk;
    logic                               rst_n;
    logic                               in_valid;
    logic                               in_ready;
    logic signed [qrsb_pkg::DATA_W-1:0] lower_end;
    logic signed [qrsb_pkg::DATA_W-1:0] upper_end;
    logic                               out_valid;
    logic                               out_ready;
    logic signed [qrsb_pkg::DATA_W-1:0] root_value;
    logic signed [qrsb_pkg::DATA_W-1:0] bracket_left;
    logic signed [qrsb_pkg::DATA_W-1:0] bracket_right;
    logic [qrsb_pkg::NUM_W-1:0]         root_number;
    logic                               found;
    logic                               overflow;
    logic                               last;
    logic                               cfg_we;
    logic                               cfg_index;
    logic [qrsb_pkg::CFG_W-1:0]         cfg_data;
    int                                 errors;
    int                                 pending;
    int                                 quiet;
    int                                 hold_token;
    int                                 hold_seen;
    int                                 stall_cnt;
    int                                 idle_cycles;

    quartic_root_scan_bisection_core dut (.*);

    quartic_root_scan_bisection_checker chk (.*);

    always
        #4 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (quiet != 0 || r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(3, 1);
        return $urandom_range(80, 20);
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_cnt <= 0;
            hold_seen <= 0;
        end
        else if (hold_seen != hold_token)
        begin
            hold_seen <= hold_token;
            stall_cnt <= 3000;
            out_ready <= 1'b0;
        end
        else if (stall_cnt > 0)
        begin
            stall_cnt <= stall_cnt - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            if (out_valid && out_ready)
                stall_cnt <= pick_gap();
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic write_reg(logic idx, logic [qrsb_pkg::CFG_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic send_interval(longint lo, longint hi);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap)
                @(posedge clk);
        end
        in_valid  <= 1'b1;
        lower_end <= qrsb_pkg::DATA_W'(lo);
        upper_end <= qrsb_pkg::DATA_W'(hi);
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (60)
            @(posedge clk);
    endtask

    task automatic send_random(int count);
        longint lo;
        longint hi;
        longint t;
        int     kind;
        for (int i = 0; i < count; i++)
        begin
            kind = $urandom_range(99);
            if (kind < 60)
            begin
                lo = longint'($urandom_range(12 * 4096)) * 4096 - 6 * ONE
                     + $urandom_range(4095);
                hi = lo + longint'($urandom_range(6 * 4096)) * 4096 + $urandom_range(4095);
                if (hi > 64'sh7FFF_FFFF)
                    hi = 64'sh7FFF_FFFF;
            end
            else
            begin
                lo = longint'(signed'($urandom()));
                hi = longint'(signed'($urandom()));
                if (kind < 85 && hi < lo)
                begin
                    t  = lo;
                    lo = hi;
                    hi = t;
                end
                else if (kind >= 95)
                    hi = lo;
            end
            send_interval(lo, hi);
        end
    endtask

    initial
    begin
        clk        = 1'b0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        lower_end  = '0;
        upper_end  = '0;
        cfg_we     = 1'b0;
        cfg_index  = qrsb_pkg::CFG_TOLERANCE;
        cfg_data   = '0;
        quiet      = 0;
        hold_token = 0;
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_interval(-64'sh8000_0000, 64'sh7FFF_FFFF);
        send_interval(0, 0);
        send_interval(5 * ONE, -5 * ONE);
        send_interval(64'sh7FFF_FFFF, -64'sh8000_0000);
        send_interval(-64'sh8000_0000, -64'sh8000_0000);
        send_interval(64'sh7FFF_FFFF, 64'sh7FFF_FFFF);
        send_interval(-5 * ONE, 5 * ONE);
        send_interval(0, ONE);
        send_interval(4 * ONE, 5 * ONE);
        send_interval(-ONE, 0);
        send_interval(0, 99);
        send_interval(-6 * ONE, -4 * ONE);
        drain();

        write_reg(qrsb_pkg::CFG_TOLERANCE, qrsb_pkg::CFG_W'(0));
        write_reg(qrsb_pkg::CFG_SUBDIVISIONS, qrsb_pkg::CFG_W'(0));
        send_interval(-5 * ONE, 5 * ONE);
        send_interval(0, ONE);
        send_interval(4 * ONE, 5 * ONE);
        send_interval(3 * ONE, 3 * ONE + 1);
        drain();

        write_reg(qrsb_pkg::CFG_TOLERANCE, qrsb_pkg::CFG_W'(16777216));
        write_reg(qrsb_pkg::CFG_SUBDIVISIONS, qrsb_pkg::CFG_W'(1023));
        send_interval(-5 * ONE, 5 * ONE);
        send_interval(-64'sh8000_0000, 64'sh7FFF_FFFF);
        send_random(6);
        drain();

        write_reg(qrsb_pkg::CFG_TOLERANCE, qrsb_pkg::CFG_W'(1));
        write_reg(qrsb_pkg::CFG_SUBDIVISIONS, qrsb_pkg::CFG_W'(7));
        send_random(80);
        hold_token <= hold_token + 1;
        send_random(20);
        drain();

        write_reg(qrsb_pkg::CFG_TOLERANCE, qrsb_pkg::CFG_W'(25'h1FF_FFFF));
        write_reg(qrsb_pkg::CFG_SUBDIVISIONS, qrsb_pkg::CFG_W'(1));
        send_random(40);
        drain();

        write_reg(qrsb_pkg::CFG_TOLERANCE, qrsb_pkg::CFG_W'(qrsb_pkg::TOL_RESET));
        write_reg(qrsb_pkg::CFG_SUBDIVISIONS, qrsb_pkg::CFG_W'(qrsb_pkg::SUB_RESET));
        quiet = 1;
        send_random(60);
        drain();
        quiet = 0;

        write_reg(qrsb_pkg::CFG_TOLERANCE, qrsb_pkg::CFG_W'(25'h0AA_AAAA));
        write_reg(qrsb_pkg::CFG_SUBDIVISIONS, qrsb_pkg::CFG_W'(10'h155));
        send_random(5);
        drain();

        write_reg(qrsb_pkg::CFG_TOLERANCE, qrsb_pkg::CFG_W'(300 + $urandom_range(5000)));
        write_reg(qrsb_pkg::CFG_SUBDIVISIONS, qrsb_pkg::CFG_W'(2 + $urandom_range(30)));
        send_random(60);
        drain();

        write_reg(qrsb_pkg::CFG_TOLERANCE, qrsb_pkg::CFG_W'($urandom_range(200, 1)));
        write_reg(qrsb_pkg::CFG_SUBDIVISIONS, qrsb_pkg::CFG_W'(10'h2AA));
        send_random(4);
        drain();
        write_reg(qrsb_pkg::CFG_SUBDIVISIONS, qrsb_pkg::CFG_W'(3 + $urandom_range(12)));
        send_random(80);
        drain();

        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
